// ----- rtl/scrolling_led_matrix_refresh_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling LED marquee checker
// ----------------------------------------------------------------------------
`ifndef SCROLLING_LED_MATRIX_REFRESH_DEFINES_SVH
`define SCROLLING_LED_MATRIX_REFRESH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SLMR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("marquee check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SLMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("marquee check failed");

`endif

// ----- rtl/slmr_pkg.sv -----
// ----------------------------------------------------------------------------
// slmr_pkg
// Shared types and constants of the scrolling LED marquee refresh block.
// ----------------------------------------------------------------------------
`default_nettype none

package slmr_pkg;

  // Operation codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SWAP    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  // Geometry of one panel
  localparam int COLS_PER_CHAR = 5;
  localparam int ROWS          = 8;
  localparam int ROW_SHIFT     = 3;   // log2 of ROWS
  localparam logic [3:0] LAST_ROW = 4'd8;
  localparam logic [3:0] FIRST_ROW = 4'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] column_address;
    logic [7:0] column_pixels;
  } in_item_t;

  typedef struct packed {
    logic [3:0] digit_register;
    logic [7:0] row_pixels;
    logic [1:0] panel_index;
    logic       group_end;
    logic       last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;      // write zero at the clear pointer of both stores
    logic wr_en;       // load a column into the back store
    logic swap;        // exchange stores, restart scroll
    logic tick;        // advance scroll offset
    logic rd_en;       // fetch the front-store column of the upcoming frame
    logic frame_next;  // step row/panel counters
    logic frame_rst;   // return counters to the first frame
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;    // clear pointer at the final entry
    logic frame_last;  // current frame is the last of the refresh
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/slmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// slmr_ctrl
// Sequencer: clearing pass after reset, the load, swap and tick operations,
// and the frame-by-frame output of a refresh.
// ----------------------------------------------------------------------------
`default_nettype none

module slmr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_operation,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output slmr_pkg::cmd_t         cmd,
  input  wire slmr_pkg::status_t status
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SHOW  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SHOW);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            slmr_pkg::OP_LOAD: cmd.wr_en = 1'b1;
            slmr_pkg::OP_SWAP: cmd.swap  = 1'b1;
            slmr_pkg::OP_TICK: cmd.tick  = 1'b1;
            default: begin
              cmd.rd_en = 1'b1;
              state_nxt = ST_SHOW;
            end
          endcase
        end
      end
      ST_SHOW: begin
        if (out_acc) begin
          if (status.frame_last) begin
            cmd.frame_rst = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.frame_next = 1'b1;
            cmd.rd_en      = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slmr_dp.sv -----
// ----------------------------------------------------------------------------
// slmr_dp
// Datapath: two column stores, scroll offset, frame counters and the
// window index arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module slmr_dp #(
  parameter int PANELS    = 4,
  parameter int MAX_CHARS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire slmr_pkg::cmd_t     cmd,
  input  wire slmr_pkg::in_item_t in_item,
  output slmr_pkg::status_t       status,
  output slmr_pkg::out_item_t     out_item
);

  localparam int BUF_LEN = MAX_CHARS * slmr_pkg::COLS_PER_CHAR;
  localparam int LEAD    = PANELS * slmr_pkg::ROWS;
  localparam int AW      = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
  localparam int OW      = $clog2(BUF_LEN + LEAD + 1);
  localparam int KW      = $clog2(BUF_LEN + 2 * LEAD + 1);
  localparam int PW      = (PANELS > 1) ? $clog2(PANELS) : 1;

  logic [7:0]    mem_a [BUF_LEN];
  logic [7:0]    mem_b [BUF_LEN];
  logic [7:0]    rdata_a_r;
  logic [7:0]    rdata_b_r;
  logic          in_range_r;

  logic          front_a_r;
  logic [OW-1:0] offset_r;
  logic [OW-1:0] offset_nxt;
  logic [AW-1:0] clr_r;
  logic [3:0]    row_r;
  logic [3:0]    row_nxt;
  logic [PW-1:0] panel_r;
  logic [PW-1:0] panel_nxt;

  logic          addr_ok;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] k;
  logic [KW-1:0] idx;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  logic          panel_end;

  // load address check
  assign addr_ok = (32'(in_item.column_address) < BUF_LEN);
  assign wr_addr = AW'(in_item.column_address);

  // frame counters: rows 1..8, panels 0..PANELS-1 within a row
  assign panel_end = (panel_r == PW'(PANELS - 1));

  always_comb begin
    row_nxt   = row_r;
    panel_nxt = panel_r;
    if (cmd.frame_rst) begin
      row_nxt   = slmr_pkg::FIRST_ROW;
      panel_nxt = '0;
    end else if (cmd.frame_next) begin
      if (panel_end) begin
        panel_nxt = '0;
        row_nxt   = row_r + 4'd1;
      end else begin
        panel_nxt = panel_r + PW'(1);
      end
    end
  end

  // window index of the upcoming frame
  assign k = KW'(offset_r) + KW'(row_nxt) + (KW'(panel_nxt) << slmr_pkg::ROW_SHIFT);
  assign idx      = k - KW'(LEAD);
  assign in_range = (k >= KW'(LEAD)) && (k < KW'(LEAD + BUF_LEN));
  assign rd_addr  = in_range ? AW'(idx) : '0;

  // scroll offset wraps after columns plus lead, and restarts on a swap
  always_comb begin
    offset_nxt = offset_r;
    if (cmd.swap) begin
      offset_nxt = '0;
    end else if (cmd.tick) begin
      if (offset_r >= OW'(BUF_LEN + LEAD)) begin
        offset_nxt = '0;
      end else begin
        offset_nxt = offset_r + OW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_a_r <= 1'b0;
      offset_r  <= '0;
      clr_r     <= '0;
      row_r     <= slmr_pkg::FIRST_ROW;
      panel_r   <= '0;
    end else begin
      if (cmd.swap) begin
        front_a_r <= !front_a_r;
      end
      offset_r <= offset_nxt;
      if (cmd.clr_en) begin
        clr_r <= clr_r + AW'(1);
      end
      row_r   <= row_nxt;
      panel_r <= panel_nxt;
    end
  end

  // store A
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem_a[clr_r] <= '0;
    end else if (cmd.wr_en && addr_ok && !front_a_r) begin
      mem_a[wr_addr] <= in_item.column_pixels;
    end
    if (cmd.rd_en) begin
      rdata_a_r <= mem_a[rd_addr];
    end
  end

  // store B
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem_b[clr_r] <= '0;
    end else if (cmd.wr_en && addr_ok && front_a_r) begin
      mem_b[wr_addr] <= in_item.column_pixels;
    end
    if (cmd.rd_en) begin
      rdata_b_r <= mem_b[rd_addr];
    end
  end

  // window mask travels with the read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      in_range_r <= in_range;
    end
  end

  // frame fields
  always_comb begin
    out_item.digit_register = row_r;
    out_item.row_pixels     = in_range_r ? (front_a_r ? rdata_a_r : rdata_b_r) : 8'd0;
    out_item.panel_index    = 2'(panel_r);
    out_item.group_end      = panel_end;
    out_item.last           = panel_end && (row_r == slmr_pkg::LAST_ROW);
  end

  assign status.clr_done   = (clr_r == AW'(BUF_LEN - 1));
  assign status.frame_last = out_item.last;

endmodule

`default_nettype wire

// ----- rtl/scrolling_led_matrix_refresh.sv -----
// ----------------------------------------------------------------------------
// scrolling_led_matrix_refresh
// Double-buffered scrolling marquee: column loads, buffer swap, scroll tick
// and refresh frames for a chain of eight-row LED panels.
// ----------------------------------------------------------------------------
// After reset both column stores are zeroed by a clearing pass during which
// in_stall is high. Load, swap and tick give no beat. A refresh gives
// 8*PANELS beats (32 by default): the first column is fetched when the
// refresh is taken, then one beat per cycle follows while out_stall stays
// low, paced by the registered read port of the front store. No new item
// is taken until the last beat of a refresh has gone.
`default_nettype none

module scrolling_led_matrix_refresh #(
  parameter int PANELS    = 4,
  parameter int MAX_CHARS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slmr_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slmr_pkg::out_item_t      out_item
);

  slmr_pkg::cmd_t    cmd;
  slmr_pkg::status_t status;

  slmr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_item.operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

  slmr_dp #(
    .PANELS    (PANELS),
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/slmr_checker.sv -----
// ----------------------------------------------------------------------------
// slmr_checker
// Port-level checks of the marquee block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scrolling_led_matrix_refresh_defines.svh"

module slmr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire slmr_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire slmr_pkg::out_item_t out_item
);

  logic refresh_acc;
  logic last_acc;

  assign refresh_acc = in_valid && !in_stall &&
                       (in_item.operation == slmr_pkg::OP_REFRESH);
  assign last_acc    = out_valid && !out_stall && out_item.last;

  // no item taken while frames are pending
  `SLMR_ASSERT_NOW(a_stall_while_out, out_valid, in_stall)
  // a refresh starts its frames in the next cycle
  `SLMR_ASSERT_NEXT(a_refresh_starts, refresh_acc, out_valid)
  // the final beat ends the run
  `SLMR_ASSERT_NEXT(a_last_ends, last_acc, !out_valid)
  // final frame is the last panel of the last row
  `SLMR_ASSERT_NOW(a_last_pos, out_valid && out_item.last,
                   out_item.group_end && (out_item.digit_register == slmr_pkg::LAST_ROW))
  // stalled beat holds
  `SLMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind scrolling_led_matrix_refresh slmr_checker u_slmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
